// File: rtl/clr_pkg.sv
package clr_pkg;

  // Field widths
  localparam int unsigned CoordW = 14;
  localparam int unsigned DeltaW = 15;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned ColorW = 16;
  localparam int unsigned ClipW  = 12;
  localparam int unsigned CfgIdxW = 2;

  // Default screen size, sets the reset clip window
  localparam int unsigned DefScreenWidth  = 320;
  localparam int unsigned DefScreenHeight = 240;

  // Command queue between front and back
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned CmdQPtrW  = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned CmdQCntW  = $clog2(CmdQDepth + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;

  // Classified command word with line set-up already worked out
  typedef struct packed {
    op_e               op;
    coord_t            start_x;
    coord_t            start_y;
    coord_t            end_x;
    coord_t            end_y;
    logic [DeltaW-1:0] delta_x;
    logic [DeltaW-1:0] delta_y;
    logic              step_x_neg;
    logic              step_y_neg;
    logic [ColorW-1:0] color;
  } cmd_t;

  // Clip window
  typedef struct packed {
    logic [ClipW-1:0] left;
    logic [ClipW-1:0] top;
    logic [ClipW-1:0] right;
    logic [ClipW-1:0] bottom;
  } clip_t;

endpackage

// File: rtl/clr_front.sv
module clr_front import clr_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  coord_t            start_x_i,
  input  coord_t            start_y_i,
  input  coord_t            end_x_i,
  input  coord_t            end_y_i,
  input  logic [ColorW-1:0] pen_color_i,
  // to command queue
  output logic              push_o,
  output cmd_t              cmd_o,
  input  logic              full_i
);

  logic signed [DeltaW-1:0] diff_x;
  logic signed [DeltaW-1:0] diff_y;

  // Accept a word whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Signed end-minus-start differences
  assign diff_x = $signed({end_x_i[CoordW-1], end_x_i}) -
                  $signed({start_x_i[CoordW-1], start_x_i});
  assign diff_y = $signed({end_y_i[CoordW-1], end_y_i}) -
                  $signed({start_y_i[CoordW-1], start_y_i});

  // Classify and build the set-up: absolute deltas and step directions
  always_comb begin
    cmd_o.op         = op_e'(operation_i);
    cmd_o.start_x    = start_x_i;
    cmd_o.start_y    = start_y_i;
    cmd_o.end_x      = end_x_i;
    cmd_o.end_y      = end_y_i;
    cmd_o.color      = pen_color_i;
    cmd_o.step_x_neg = diff_x[DeltaW-1] || (diff_x == '0);
    cmd_o.step_y_neg = diff_y[DeltaW-1] || (diff_y == '0);
    cmd_o.delta_x    = diff_x[DeltaW-1] ? DeltaW'(-diff_x) : DeltaW'(diff_x);
    cmd_o.delta_y    = diff_y[DeltaW-1] ? DeltaW'(-diff_y) : DeltaW'(diff_y);
  end

endmodule

// File: rtl/clr_cmd_fifo.sv
module clr_cmd_fifo import clr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t                mem_q [CmdQDepth];
  logic [CmdQPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdQPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdQCntW-1:0] count_q, count_d;
  logic                do_pop;

  assign full_o  = (count_q == CmdQCntW'(CmdQDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CmdQPtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CmdQPtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/clr_back.sv
module clr_back import clr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clip_t             clip_i,
  // from command queue
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  // pixel channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output coord_t            pixel_x_o,
  output coord_t            pixel_y_o,
  output logic [ColorW-1:0] pixel_color_o,
  output logic              visible_o,
  output logic              last_o
);

  localparam int unsigned E2W = ErrW + 1;

  // Line state
  logic                     busy_q;
  coord_t                   cur_x_q, cur_y_q;
  coord_t                   target_x_q, target_y_q;
  logic [DeltaW-1:0]        delta_x_q, delta_y_q;
  logic                     step_x_neg_q, step_y_neg_q;
  logic signed [ErrW-1:0]   err_q;
  logic [ColorW-1:0]        color_q;

  // Output register
  logic                     out_valid_q;
  coord_t                   pix_x_q, pix_y_q;
  logic [ColorW-1:0]        pix_color_q;
  logic                     visible_q, last_q;

  logic                     slot_free;
  logic                     is_load, is_step, emit;
  logic                     at_end, vis;
  logic signed [E2W-1:0]    e2, dx_ext, dy_ext, err_ext, err_next;
  logic                     move_x, move_y;
  logic signed [ErrW-1:0]   err_init;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_load   = cmd_valid_i && (cmd_i.op == OP_LOAD);
  assign is_step   = cmd_valid_i && (cmd_i.op == OP_STEP);
  // A step while idle drains without a pixel
  assign pop_o     = is_load || (is_step && (!busy_q || slot_free));
  assign emit      = is_step && busy_q && slot_free;

  assign at_end = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);

  // Inclusive window test; negative positions are never inside
  assign vis = !cur_x_q[CoordW-1] && !cur_y_q[CoordW-1] &&
               ({1'b0, clip_i.left}  <= cur_x_q[CoordW-2:0]) &&
               ({1'b0, clip_i.right} >= cur_x_q[CoordW-2:0]) &&
               ({1'b0, clip_i.top}    <= cur_y_q[CoordW-2:0]) &&
               ({1'b0, clip_i.bottom} >= cur_y_q[CoordW-2:0]);

  // Bresenham decision on the doubled error
  assign dx_ext   = $signed({{(E2W-DeltaW){1'b0}}, delta_x_q});
  assign dy_ext   = $signed({{(E2W-DeltaW){1'b0}}, delta_y_q});
  assign err_ext  = $signed({err_q[ErrW-1], err_q});
  assign e2       = $signed({err_q, 1'b0});
  assign move_x   = e2 > -dx_ext;
  assign move_y   = e2 < dy_ext;
  assign err_next = err_ext - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

  // Initial error: half the major delta, sign picks the major axis
  assign err_init = (cmd_i.delta_x > cmd_i.delta_y) ?
                    $signed({{(ErrW-DeltaW+1){1'b0}}, cmd_i.delta_x[DeltaW-1:1]}) :
                    -$signed({{(ErrW-DeltaW+1){1'b0}}, cmd_i.delta_y[DeltaW-1:1]});

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (is_load) begin
        busy_q <= 1'b1;
      end else if (emit && at_end) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Line registers: latch on load, advance one step per pixel
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      cur_x_q      <= cmd_i.start_x;
      cur_y_q      <= cmd_i.start_y;
      target_x_q   <= cmd_i.end_x;
      target_y_q   <= cmd_i.end_y;
      delta_x_q    <= cmd_i.delta_x;
      delta_y_q    <= cmd_i.delta_y;
      step_x_neg_q <= cmd_i.step_x_neg;
      step_y_neg_q <= cmd_i.step_y_neg;
      err_q        <= err_init;
      color_q      <= cmd_i.color;
    end else if (emit && !at_end) begin
      err_q <= err_next[ErrW-1:0];
      if (move_x) begin
        cur_x_q <= step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (move_y) begin
        cur_y_q <= step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
  end

  // Hold the pixel word until taken
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q     <= cur_x_q;
      pix_y_q     <= cur_y_q;
      pix_color_q <= color_q;
      visible_q   <= vis;
      last_q      <= at_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign visible_o     = visible_q;
  assign last_o        = last_q;

endmodule

// File: rtl/clipped_line_rasterizer.sv
// Bresenham line stepper with a per-pixel clip window. Send a load word
// (operation 0) with both end points and the colour, then one step word
// (operation 1) per pixel; each step while a line is active returns one
// pixel word with its position, colour, an inclusive clip-window flag and
// a last flag on the end point, after which the stepper goes idle and
// further steps return nothing. A load never returns a word and abandons
// any line in progress. One word per clock is sustained in both
// directions while the pixel side accepts them; the rate is set by the
// error update in the back end. An accepted step word is written into
// the command queue and, once the output register is free, moves into
// that register, which offers the pixel. The two-entry command queue
// lets the input side keep taking words until it is full while the
// pixel side is stalled. Write the clip registers only while idle.
module clipped_line_rasterizer import clr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ClipW-1:0]   cfg_wdata_i,
  // command channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  coord_t             start_x_i,
  input  coord_t             start_y_i,
  input  coord_t             end_x_i,
  input  coord_t             end_y_i,
  input  logic [ColorW-1:0]  pen_color_i,
  // pixel channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output coord_t             pixel_x_o,
  output coord_t             pixel_y_o,
  output logic [ColorW-1:0]  pixel_color_o,
  output logic               visible_o,
  output logic               last_o
);

  clip_t clip_q;
  logic  push, full, cmd_valid, pop;
  cmd_t  front_cmd, queue_cmd;

  // Clip window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q.left   <= '0;
      clip_q.top    <= '0;
      clip_q.right  <= ClipW'(SCREEN_WIDTH - 1);
      clip_q.bottom <= ClipW'(SCREEN_HEIGHT - 1);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CLIP_LEFT:   clip_q.left   <= cfg_wdata_i;
        REG_CLIP_TOP:    clip_q.top    <= cfg_wdata_i;
        REG_CLIP_RIGHT:  clip_q.right  <= cfg_wdata_i;
        REG_CLIP_BOTTOM: clip_q.bottom <= cfg_wdata_i;
        default:         clip_q        <= clip_q;
      endcase
    end
  end

  clr_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .pen_color_i (pen_color_i),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .full_i      (full)
  );

  clr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (pop)
  );

  clr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clip_i        (clip_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .visible_o     (visible_o),
    .last_o        (last_o)
  );

endmodule
